/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL file of the queue core.
// Under SYNTHESIS the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/bthq_pkg.sv */
// Types and constants of the Braun tree priority queue.
// Used by bthq_mem and the top level; depends on nothing.
`timescale 1ns / 1ps
package bthq_pkg;
   localparam int KEY_W   = 32;
   localparam int TAG_W   = 32;
   localparam int COUNT_W = 9;

   localparam logic ACT_ENQ = 1'b0;
   localparam logic ACT_DEQ = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } slot_type;
endpackage

/* hw/rtl/braun_tree_min_heap_queue_core.sv */
// Braun tree min-priority queue: enqueue/dequeue words in, one status word out.
// Depends on bthq_pkg, bthq_mem and assert_macros.svh.
//
// Usage: the request channel (req_*) carries an action, a 16.16 priority and
// a payload. Action 0 enqueues, action 1 dequeues the item of lowest priority.
// Every request gives exactly one response word on the rsp_* channel with a
// status, the dequeued priority and payload (zero otherwise) and the count.
// One request is worked on at a time; req_stall is high while it is busy.
// An operation walks the tree one level per cycle through the slot memory:
// one write per level and one read (two on dequeue) from the registered ports.
// The response is held in an output register; a stalled response keeps its
// word, and a finished operation waits for that register before the next
// request is accepted. Synchronous reset empties the queue at once; the slot
// memory is not cleared, since only written slots are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module braun_tree_min_heap_queue_core #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [bthq_pkg::KEY_W-1:0]   req_priority_req,
   input  logic [bthq_pkg::TAG_W-1:0]   req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [bthq_pkg::TAG_W-1:0]   rsp_payload_out,
   output logic [bthq_pkg::KEY_W-1:0]   rsp_priority_out,
   output logic [bthq_pkg::COUNT_W-1:0] rsp_count
);
   import bthq_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY + 1);
   localparam int unsigned DW = $clog2(AW + 1);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_ENQ_WALK  = 3'd1;
   localparam logic [2:0] ST_ENQ_LAST  = 3'd2;
   localparam logic [2:0] ST_DEQ_FIRST = 3'd3;
   localparam logic [2:0] ST_DEQ_WALK  = 3'd4;
   localparam logic [2:0] ST_DEQ_LAST  = 3'd5;
   localparam logic [2:0] ST_POST      = 3'd6;

   function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] x,
                                                input logic [DW-1:0] dx);
      logic [AW-1:0] half;
      logic [AW-1:0] full;
      half = AW'(1) << (dx - DW'(1));
      full = AW'(1) << dx;
      return (x < full + half) ? x - half : x - full;
   endfunction

   logic [2:0]     state_ff, state_in;
   logic [AW-1:0]  count_ff, count_in;
   slot_type       cur_ff, cur_in;
   logic [AW-1:0]  g_ff, g_in;
   logic [DW-1:0]  gd_ff, gd_in;
   logic [AW-1:0]  p_ff, p_in;
   logic [DW-1:0]  pd_ff, pd_in;
   logic [AW:0]    lc_ff, lc_in;
   logic [AW:0]    rc_ff, rc_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [KEY_W-1:0] res_pri_ff, res_pri_in;
   logic [TAG_W-1:0] res_pay_ff, res_pay_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]     rsp_pay_ff, rsp_pay_in;
   logic [KEY_W-1:0]     rsp_pri_ff, rsp_pri_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic          we;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   slot_type      rd_a;
   slot_type      rd_b;

   logic          accept;
   logic          out_free;
   logic          enq_full;
   logic [AW-1:0] g0;
   logic [DW-1:0] d0;
   logic [AW:0]   n_ext;
   logic          use_right;
   logic [AW-1:0] best_addr;
   slot_type      best_val;
   logic          enq_swap;
   logic [AW:0]   nlc;
   logic [AW:0]   nrc;
   slot_type      new_item;

   bthq_mem #(.AW(AW)) u_mem (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign enq_full = accept && (req_action == ACT_ENQ) && (count_ff == AW'(CAPACITY));
   assign g0 = count_ff + AW'(1);
   assign n_ext = {1'b0, count_ff};
   assign new_item = '{key: req_priority_req, tag: req_payload};

   always_comb begin
      d0 = '0;
      for (int i = 0; i < AW; i++) begin
         if (g0[i]) d0 = DW'(i);
      end
   end

   // Sift-down choice: the right child wins ties, the node moves on >=.
   assign use_right = (rc_ff <= n_ext) && (rd_a.key >= rd_b.key);
   assign best_addr = use_right ? rc_ff[AW-1:0] : lc_ff[AW-1:0];
   assign best_val  = use_right ? rd_b : rd_a;
   assign nlc = {1'b0, best_addr} + ((AW+1)'(1) << ({1'b0, gd_ff} + (DW+1)'(1)));
   assign nrc = {1'b0, best_addr} + ((AW+1)'(1) << ({1'b0, gd_ff} + (DW+1)'(2)));
   assign enq_swap = (rd_a.key >= cur_ff.key);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      g_in          = g_ff;
      gd_in         = gd_ff;
      p_in          = p_ff;
      pd_in         = pd_ff;
      lc_in         = lc_ff;
      rc_in         = rc_ff;
      res_status_in = res_status_ff;
      res_pri_in    = res_pri_ff;
      res_pay_in    = res_pay_ff;
      we            = 1'b0;
      wr_addr       = g_ff;
      wr_data       = cur_ff;
      rd_addr_a     = p_ff;
      rd_addr_b     = p_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_status_in = STATUS_DONE;
               res_pri_in    = '0;
               res_pay_in    = '0;
               if (req_action == ACT_ENQ) begin
                  if (count_ff == AW'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_POST;
                  end else begin
                     count_in = g0;
                     cur_in   = new_item;
                     g_in     = g0;
                     if (g0 == AW'(1)) begin
                        we       = 1'b1;
                        wr_addr  = g0;
                        wr_data  = new_item;
                        state_in = ST_POST;
                     end else begin
                        p_in      = parent_of(g0, d0);
                        pd_in     = d0 - DW'(1);
                        rd_addr_a = parent_of(g0, d0);
                        state_in  = ST_ENQ_WALK;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_POST;
                  end else begin
                     rd_addr_a = AW'(1);
                     rd_addr_b = count_ff;
                     count_in  = count_ff - AW'(1);
                     state_in  = ST_DEQ_FIRST;
                  end
               end
            end
         end
         ST_ENQ_WALK: begin
            // Each level writes the item with the larger key (the parent on a tie) and carries the other up.
            we      = 1'b1;
            wr_addr = g_ff;
            wr_data = enq_swap ? rd_a : cur_ff;
            cur_in  = enq_swap ? cur_ff : rd_a;
            g_in    = p_ff;
            if (p_ff == AW'(1)) begin
               state_in = ST_ENQ_LAST;
            end else begin
               p_in      = parent_of(p_ff, pd_ff);
               pd_in     = pd_ff - DW'(1);
               rd_addr_a = parent_of(p_ff, pd_ff);
            end
         end
         ST_ENQ_LAST: begin
            we       = 1'b1;
            wr_addr  = g_ff;
            wr_data  = cur_ff;
            state_in = ST_POST;
         end
         ST_DEQ_FIRST: begin
            res_pri_in = rd_a.key;
            res_pay_in = rd_a.tag;
            cur_in     = rd_b;
            g_in       = AW'(1);
            gd_in      = '0;
            lc_in      = (AW+1)'(2);
            rc_in      = (AW+1)'(3);
            if (count_ff == '0) begin
               state_in = ST_POST;
            end else if (count_ff == AW'(1)) begin
               we       = 1'b1;
               wr_addr  = AW'(1);
               wr_data  = rd_b;
               state_in = ST_POST;
            end else begin
               rd_addr_a = AW'(2);
               rd_addr_b = AW'(3);
               state_in  = ST_DEQ_WALK;
            end
         end
         ST_DEQ_WALK: begin
            we      = 1'b1;
            wr_addr = g_ff;
            if (cur_ff.key >= best_val.key) begin
               wr_data = best_val;
               g_in    = best_addr;
               gd_in   = gd_ff + DW'(1);
               lc_in   = nlc;
               rc_in   = nrc;
               if (nlc > n_ext) begin
                  state_in = ST_DEQ_LAST;
               end else begin
                  rd_addr_a = nlc[AW-1:0];
                  rd_addr_b = nrc[AW-1:0];
               end
            end else begin
               wr_data  = cur_ff;
               state_in = ST_POST;
            end
         end
         ST_DEQ_LAST: begin
            we       = 1'b1;
            wr_addr  = g_ff;
            wr_data  = cur_ff;
            state_in = ST_POST;
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_pri_in    = res_pri_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      g_ff          <= g_in;
      gd_ff         <= gd_in;
      p_ff          <= p_in;
      pd_ff         <= pd_in;
      lc_ff         <= lc_in;
      rc_ff         <= rc_in;
      res_status_ff <= res_status_in;
      res_pri_ff    <= res_pri_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_out  = rsp_pay_ff;
   assign rsp_priority_out = rsp_pri_ff;
   assign rsp_count        = rsp_count_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= AW'(CAPACITY))
   `ASSERT_IMPLIES(a_no_slot_zero, clock, reset, we, wr_addr != '0)
   `ASSERT_IMPLIES(a_rsp_from_post, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_POST)
   `ASSERT_NEXT(a_full_keeps_count, clock, reset, enq_full, count_ff == AW'(CAPACITY))
endmodule

/* hw/rtl/bthq_mem.sv */
// Slot memory of the queue: one write port, two registered read ports.
// Depends on bthq_pkg for the slot word type.
`timescale 1ns / 1ps
module bthq_mem #(
   parameter int unsigned AW = 9
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  bthq_pkg::slot_type    wr_data,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output bthq_pkg::slot_type    rd_data_a,
   output bthq_pkg::slot_type    rd_data_b
);
   import bthq_pkg::*;

   slot_type mem [2**AW];
   slot_type rd_a_ff;
   slot_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule
